@@ rtl/bsd_pkg.sv @@
// ----------------------------------------------------------------------------
// bsd_pkg
// Shared types and character codes for the backslash escape decoder.
// ----------------------------------------------------------------------------
package bsd_pkg;

	// result slots per input item
	localparam int MAX_RES = 3;

	// escape phase codes
	localparam logic [1:0] PH_PLAIN = 2'd0;
	localparam logic [1:0] PH_BSL   = 2'd1;
	localparam logic [1:0] PH_HEX   = 2'd2;
	localparam logic [1:0] PH_OCT   = 2'd3;

	// character codes
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_SEVEN  = 8'h37;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_LO_A   = 8'h61;
	localparam logic [7:0] CH_LO_F   = 8'h66;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_F   = 8'h46;
	localparam logic [7:0] CH_LO_B   = 8'h62;
	localparam logic [7:0] CH_LO_C   = 8'h63;
	localparam logic [7:0] CH_LO_E   = 8'h65;
	localparam logic [7:0] CH_LO_N   = 8'h6E;
	localparam logic [7:0] CH_LO_R   = 8'h72;
	localparam logic [7:0] CH_LO_T   = 8'h74;
	localparam logic [7:0] CH_LO_V   = 8'h76;
	localparam logic [7:0] CH_LO_X   = 8'h78;

	// decoded control values
	localparam logic [7:0] VAL_BEL = 8'd7;
	localparam logic [7:0] VAL_BS  = 8'd8;
	localparam logic [7:0] VAL_TAB = 8'd9;
	localparam logic [7:0] VAL_LF  = 8'd10;
	localparam logic [7:0] VAL_VT  = 8'd11;
	localparam logic [7:0] VAL_FF  = 8'd12;
	localparam logic [7:0] VAL_CR  = 8'd13;
	localparam logic [7:0] VAL_ESC = 8'd27;

	// escape mode codes
	localparam logic MODE_FORMAT = 1'b0;
	localparam logic MODE_PCT_B  = 1'b1;

	// decoder state between items
	typedef struct packed {
		logic [1:0] phase;
		logic [1:0] cnt;
		logic [8:0] acc;
		logic       halted;
	} esc_state_t;

	// all results caused by one item
	typedef struct packed {
		logic [1:0]                 count;
		logic [MAX_RES-1:0][7:0]    bytes;
		logic [MAX_RES-1:0]         has;
		logic                       done;
		logic                       stopped;
	} res_batch_t;

endpackage

@@ rtl/bsd_decode.sv @@
// ----------------------------------------------------------------------------
// bsd_decode
// Single-pass escape logic: one character and the current state give the
// next state and up to three result bytes.
// ----------------------------------------------------------------------------
module bsd_decode (
	input  logic [7:0]          in_byte,
	input  logic                end_mark,
	input  logic                escape_mode,
	input  bsd_pkg::esc_state_t cur,
	output bsd_pkg::esc_state_t nxt,
	output bsd_pkg::res_batch_t batch
);
	import bsd_pkg::*;

	// append one result to the batch
	function automatic res_batch_t push(res_batch_t b, logic [7:0] v, logic h);
		res_batch_t r;
		r = b;
		r.bytes[r.count] = h ? v : 8'd0;
		r.has[r.count]   = h;
		r.count          = r.count + 2'd1;
		return r;
	endfunction

	// hex digit check, valid flag above the value
	function automatic logic [4:0] hex_digit(logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= CH_LO_A && c <= CH_LO_F) || (c >= CH_UP_A && c <= CH_UP_F)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

	logic [4:0] hex_v;
	logic       is_oct;
	logic [7:0] simple_v;
	logic       simple_hit;
	res_batch_t b;
	esc_state_t s;

	assign hex_v  = hex_digit(in_byte);
	assign is_oct = (in_byte >= CH_ZERO) && (in_byte <= CH_SEVEN);

	// fixed single-letter escapes
	always_comb begin
		simple_hit = 1'b1;
		simple_v   = 8'd0;
		unique case (in_byte)
			CH_BSLASH: simple_v = CH_BSLASH;
			CH_LO_A:   simple_v = VAL_BEL;
			CH_LO_B:   simple_v = VAL_BS;
			CH_LO_F:   simple_v = VAL_FF;
			CH_LO_N:   simple_v = VAL_LF;
			CH_LO_R:   simple_v = VAL_CR;
			CH_LO_T:   simple_v = VAL_TAB;
			CH_LO_V:   simple_v = VAL_VT;
			default:   simple_hit = 1'b0;
		endcase
	end

	// escape state walk
	always_comb begin
		b       = '0;
		s       = cur;
		b.done  = end_mark;
		if (end_mark) begin
			// flush whatever is pending
			unique case (cur.phase)
				PH_BSL: b = push(b, CH_BSLASH, 1'b1);
				PH_HEX: begin
					if (cur.cnt == 2'd0) begin
						b = push(b, CH_BSLASH, 1'b1);
						b = push(b, CH_LO_X, 1'b1);
					end else begin
						b = push(b, cur.acc[7:0], 1'b1);
					end
				end
				PH_OCT:  b = push(b, cur.acc[7:0], 1'b1);
				default: b = b;
			endcase
			if (b.count == 2'd0) begin
				b = push(b, 8'd0, 1'b0);
			end
			b.stopped = cur.halted;
			s         = '0;
		end else if (cur.halted) begin
			// output stopped until the end marker
			b.stopped = 1'b1;
		end else begin
			unique case (cur.phase)
				PH_PLAIN: begin
					if (in_byte == CH_BSLASH) begin
						s.phase = PH_BSL;
					end else begin
						b = push(b, in_byte, 1'b1);
					end
				end
				PH_BSL: begin
					s.phase = PH_PLAIN;
					if (simple_hit) begin
						b = push(b, simple_v, 1'b1);
					end else if (escape_mode == MODE_FORMAT && in_byte == CH_LO_E) begin
						b = push(b, VAL_ESC, 1'b1);
					end else if (escape_mode == MODE_FORMAT && in_byte == CH_LO_X) begin
						s.phase = PH_HEX;
						s.cnt   = 2'd0;
						s.acc   = 9'd0;
					end else if (escape_mode == MODE_FORMAT && is_oct) begin
						s.phase = PH_OCT;
						s.cnt   = 2'd1;
						s.acc   = {6'd0, in_byte[2:0]};
					end else if (escape_mode == MODE_PCT_B && in_byte == CH_LO_C) begin
						s.halted = 1'b1;
						b        = push(b, 8'd0, 1'b0);
					end else if (escape_mode == MODE_PCT_B && in_byte == CH_ZERO) begin
						s.phase = PH_OCT;
						s.cnt   = 2'd0;
						s.acc   = 9'd0;
					end else begin
						b = push(b, CH_BSLASH, 1'b1);
						b = push(b, in_byte, 1'b1);
					end
				end
				PH_HEX: begin
					if (hex_v[4] && cur.cnt < 2'd2) begin
						s.acc = {cur.acc[4:0], hex_v[3:0]};
						s.cnt = cur.cnt + 2'd1;
						if (s.cnt == 2'd2) begin
							b = push(b, s.acc[7:0], 1'b1);
							s = '{phase: PH_PLAIN, cnt: 2'd0, acc: 9'd0, halted: cur.halted};
						end
					end else begin
						// digit run ends, character handled as plain text
						if (cur.cnt == 2'd0) begin
							b = push(b, CH_BSLASH, 1'b1);
							b = push(b, CH_LO_X, 1'b1);
						end else begin
							b = push(b, cur.acc[7:0], 1'b1);
						end
						s.cnt = 2'd0;
						s.acc = 9'd0;
						if (in_byte == CH_BSLASH) begin
							s.phase = PH_BSL;
						end else begin
							s.phase = PH_PLAIN;
							b       = push(b, in_byte, 1'b1);
						end
					end
				end
				default: begin
					if (is_oct && cur.cnt < 2'd3) begin
						s.acc = {cur.acc[5:0], in_byte[2:0]};
						s.cnt = cur.cnt + 2'd1;
						if (s.cnt == 2'd3) begin
							b = push(b, s.acc[7:0], 1'b1);
							s = '{phase: PH_PLAIN, cnt: 2'd0, acc: 9'd0, halted: cur.halted};
						end
					end else begin
						b     = push(b, cur.acc[7:0], 1'b1);
						s.cnt = 2'd0;
						s.acc = 9'd0;
						if (in_byte == CH_BSLASH) begin
							s.phase = PH_BSL;
						end else begin
							s.phase = PH_PLAIN;
							b       = push(b, in_byte, 1'b1);
						end
					end
				end
			endcase
			b.stopped = s.halted;
		end
	end

	assign nxt   = s;
	assign batch = b;

endmodule

@@ rtl/bsd_out_buf.sv @@
// ----------------------------------------------------------------------------
// bsd_out_buf
// Result register: holds the batch of one item and hands its results out
// one per cycle while res_ready is high.
// ----------------------------------------------------------------------------
module bsd_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  bsd_pkg::res_batch_t batch,
	output logic                free,
	output logic                res_valid,
	input  logic                res_ready,
	output logic [7:0]          res_byte,
	output logic                res_has,
	output logic                res_last,
	output logic                res_done,
	output logic                res_stopped
);
	import bsd_pkg::*;

	res_batch_t ent_q;
	logic [1:0] pos_q;
	logic [1:0] rem_q;
	logic       take;

	assign res_valid = (rem_q != 2'd0);
	assign take      = res_valid && res_ready;
	assign free      = (rem_q == 2'd0) || (take && rem_q == 2'd1);

	// read pointer and remaining count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 2'd0;
			rem_q <= 2'd0;
		end else if (load) begin
			pos_q <= 2'd0;
			rem_q <= batch.count;
		end else if (take) begin
			pos_q <= pos_q + 2'd1;
			rem_q <= rem_q - 2'd1;
		end
	end

	// batch payload
	always_ff @(posedge clk) begin
		if (load) begin
			ent_q <= batch;
		end
	end

	// current result
	assign res_byte    = ent_q.bytes[pos_q];
	assign res_has     = ent_q.has[pos_q];
	assign res_last    = (rem_q == 2'd1);
	assign res_done    = ent_q.done && (rem_q == 2'd1);
	assign res_stopped = ent_q.stopped;

endmodule

@@ rtl/backslash_escape_decoder.sv @@
// ----------------------------------------------------------------------------
// backslash_escape_decoder
// Streaming decoder of backslash escapes, one character per request.
// ----------------------------------------------------------------------------
// A character request is registered, decoded in one pass against the escape
// state and its results (up to three) land in a result register that drains
// one result per cycle while m_axis_tready is high. Plain text flows at one
// character per cycle while the output is ready; an item with k results
// holds the input until its last result is taken at the single result port.
// The escape mode is to be written on the cfg channel only while the stream
// is idle; the block itself does not enforce this.
module backslash_escape_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data,        // escape_mode
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,    // [7:0] in_byte
	input  logic       s_axis_tlast,    // end_mark
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,    // [7:0] out_byte
	output logic       m_axis_tlast,    // run_last
	output logic [2:0] m_axis_tuser     // [0] has_byte, [1] done_res, [2] stopped
);
	import bsd_pkg::*;

	logic       mode_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;
	esc_state_t esc_q;
	esc_state_t esc_nxt;
	res_batch_t batch;
	logic       free;
	logic       load;

	// mode register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_FORMAT;
		end else if (cfg_valid) begin
			mode_q <= cfg_data;
		end
	end

	// input register
	assign load          = valid_s1 && free;
	assign s_axis_tready = !valid_s1 || load;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			end_s1  <= s_axis_tlast;
		end
	end

	// escape logic
	bsd_decode u_decode (
		.in_byte     (byte_s1),
		.end_mark    (end_s1),
		.escape_mode (mode_q),
		.cur         (esc_q),
		.nxt         (esc_nxt),
		.batch       (batch)
	);

	// escape state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q <= '0;
		end else if (load) begin
			esc_q <= esc_nxt;
		end
	end

	// result register
	bsd_out_buf u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (load),
		.batch       (batch),
		.free        (free),
		.res_valid   (m_axis_tvalid),
		.res_ready   (m_axis_tready),
		.res_byte    (m_axis_tdata),
		.res_has     (m_axis_tuser[0]),
		.res_last    (m_axis_tlast),
		.res_done    (m_axis_tuser[1]),
		.res_stopped (m_axis_tuser[2])
	);

endmodule

@@ rtl/bsd_checker.sv @@
// ----------------------------------------------------------------------------
// bsd_checker
// Port-level checks on the result stream of the escape decoder.
// ----------------------------------------------------------------------------
module bsd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tlast,
	input logic [2:0] m_axis_tuser
);

	// stalled result request holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
		&& $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// end of string closes the item's results
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
		else $error("done result not last");

	// bare result carries a zero byte
	a_bare_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 8'd0)
		else $error("bare result with data");

	// bare result always stands alone
	a_bare_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast)
		else $error("bare result not last");

endmodule

bind backslash_escape_decoder bsd_checker u_bsd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);
